// ===== hw/rtl/crtm_pkg.sv =====
package crtm_pkg;

	localparam int unsigned WORD_BITS_DEF = 64;
	localparam int unsigned DW = 64;

	localparam logic [1:0] ST_MERGED = 2'd0;
	localparam logic [1:0] ST_ZERO_MOD = 2'd1;
	localparam logic [1:0] ST_NO_SOL = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef enum logic [3:0] {
		SP_RRED,
		SP_GCD,
		SP_QM,
		SP_RG,
		SP_AG,
		SP_LIM,
		SP_DIFF,
		SP_DMOD,
		SP_PG,
		SP_R0,
		SP_EUC,
		SP_SUPD,
		SP_K,
		SP_PQ,
		SP_PK
	} step_t;

	typedef struct packed {
		logic       load;
		logic       start;
		logic       commit;
		logic       emit;
		step_t      step;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic m_zero;
		logic y_zero;
		logic mis;
		logic ovf;
		logic q_gt1;
	} stat_t;

	function automatic logic is_mul_step(step_t s);
		return (s == SP_SUPD) || (s == SP_K) || (s == SP_PQ) || (s == SP_PK);
	endfunction

endpackage

// ===== hw/rtl/crtm_div.sv =====
module crtm_div import crtm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int unsigned CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] dv_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dv_q  <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DW'(trial - {1'b0, dv_q}) : trial[DW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign busy = cnt_q != '0;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

// ===== hw/rtl/crtm_mulmod.sv =====
module crtm_mulmod import crtm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          plain,
	input  logic [DW-1:0] opa,
	input  logic [DW-1:0] opb,
	input  logic [DW-1:0] modv,
	output logic          busy,
	output logic [DW-1:0] prod
);
	logic          busy_q;
	logic          plain_q;
	logic [DW-1:0] acc_q;
	logic [DW-1:0] aa_q;
	logic [DW-1:0] bb_q;
	logic [DW-1:0] mm_q;
	logic [DW-1:0] acc_sum;
	logic [DW-1:0] aa_dbl;

	always_comb begin
		acc_sum = acc_q + aa_q;
		aa_dbl  = aa_q + aa_q;
		if (!plain_q) begin
			if (acc_sum >= mm_q) acc_sum = acc_sum - mm_q;
			if (aa_dbl >= mm_q) aa_dbl = aa_dbl - mm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (bb_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	// double and add, one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			aa_q    <= opa;
			bb_q    <= opb;
			mm_q    <= modv;
			plain_q <= plain;
		end else if (busy_q && bb_q != '0) begin
			if (bb_q[0]) acc_q <= acc_sum;
			aa_q <= aa_dbl;
			bb_q <= bb_q >> 1;
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;
endmodule

// ===== hw/rtl/crtm_dp.sv =====
module crtm_dp import crtm_pkg::*; #(
	parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	output stat_t         stat,
	input  logic          restart,
	input  logic [63:0]   modulus,
	input  logic [63:0]   remainder,
	output logic [1:0]    status,
	output logic [62:0]   period,
	output logic [62:0]   residue
);
	localparam logic [DW-1:0] LIMIT = DW'((65'd1 << (WORD_BITS - 1)) - 65'd1);

	logic [DW-1:0] p_q, a_q, m_q, r_q, t_q, x_q, y_q, g_q, qq_q, d_q, s0_q, s1_q;
	logic          rneg_q;
	logic [1:0]    status_q;
	logic [62:0]   period_q, residue_q;

	logic          div_start, mul_start, mul_plain, div_busy, mul_busy, ge;
	logic [DW-1:0] dn, dv, quo, rem, ma, mb, mm, prod, sdiff;

	assign ge = r_q >= a_q;

	always_comb begin
		dn = x_q;
		dv = y_q;
		ma = s1_q;
		mb = t_q;
		mm = qq_q;
		mul_plain = 1'b0;
		case (cmd.step)
			SP_RRED: begin dn = t_q;  dv = m_q; end
			SP_QM:   begin dn = m_q;  dv = g_q; end
			SP_RG:   begin dn = r_q;  dv = g_q; end
			SP_AG:   begin dn = a_q;  dv = g_q; end
			SP_LIM:  begin dn = LIMIT; dv = p_q; end
			SP_DIFF: begin dn = ge ? r_q - a_q : a_q - r_q; dv = g_q; end
			SP_DMOD: begin dn = t_q;  dv = qq_q; end
			SP_PG:   begin dn = p_q;  dv = g_q; end
			SP_R0:   begin dn = t_q;  dv = qq_q; end
			SP_K:    begin ma = d_q;  mb = s0_q; end
			SP_PQ:   begin ma = p_q;  mb = qq_q; mul_plain = 1'b1; end
			SP_PK:   begin ma = p_q;  mb = s1_q; mul_plain = 1'b1; end
			default: ;
		endcase
		div_start = cmd.start && !is_mul_step(cmd.step);
		mul_start = cmd.start && is_mul_step(cmd.step);
	end

	crtm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dn), .divisor(dv),
		.busy(div_busy), .quo(quo), .rem(rem)
	);

	crtm_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .plain(mul_plain),
		.opa(ma), .opb(mb), .modv(mm), .busy(mul_busy), .prod(prod)
	);

	assign sdiff = (s0_q >= prod) ? s0_q - prod : s0_q + (qq_q - prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= DW'(1);
			a_q <= '0;
		end else if (cmd.load && restart) begin
			p_q <= DW'(1);
			a_q <= '0;
		end else if (cmd.commit && cmd.step == SP_PK) begin
			p_q <= x_q;
			a_q <= a_q + prod;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q    <= modulus[63] ? -modulus : modulus;
			t_q    <= remainder[63] ? -remainder : remainder;
			rneg_q <= remainder[63];
		end
		if (cmd.commit) begin
			case (cmd.step)
				SP_RRED: begin
					r_q <= (rneg_q && rem != '0) ? m_q - rem : rem;
					x_q <= p_q;
					y_q <= m_q;
				end
				SP_GCD: begin
					if (y_q == '0) begin
						g_q <= x_q;
					end else begin
						x_q <= y_q;
						y_q <= rem;
					end
				end
				SP_QM:   qq_q <= quo;
				SP_RG:   t_q <= rem;
				SP_DIFF: t_q <= quo;
				SP_DMOD: d_q <= (ge || rem == '0) ? rem : qq_q - rem;
				SP_PG:   t_q <= quo;
				SP_R0: begin
					x_q  <= rem;
					y_q  <= qq_q;
					s0_q <= DW'(1);
					s1_q <= '0;
				end
				SP_EUC: begin
					x_q <= y_q;
					y_q <= rem;
					t_q <= quo;
				end
				SP_SUPD: begin
					s0_q <= s1_q;
					s1_q <= sdiff;
				end
				SP_K:  s1_q <= prod;
				SP_PQ: x_q <= prod;
				default: ;
			endcase
		end
		if (cmd.emit) begin
			status_q  <= cmd.code;
			period_q  <= p_q[62:0];
			residue_q <= a_q[62:0];
		end
	end

	assign stat.busy   = div_busy || mul_busy;
	assign stat.m_zero = modulus == '0;
	assign stat.y_zero = y_q == '0;
	assign stat.mis    = rem != t_q;
	assign stat.ovf    = qq_q > quo;
	assign stat.q_gt1  = qq_q > DW'(1);

	assign status  = status_q;
	assign period  = period_q;
	assign residue = residue_q;
endmodule

// ===== hw/rtl/crtm_ctrl.sv =====
module crtm_ctrl import crtm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);
	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

	state_t     st_q;
	step_t      step_q;
	logic       ph_q;
	logic [1:0] code_q;
	logic       out_valid_q;
	logic       accept, emit, div_y0;

	assign accept = in_valid && st_q == S_IDLE;
	assign emit   = st_q == S_DONE && (!out_valid_q || !out_stall);
	// gcd or Euclid step with a zero divisor ends its loop
	assign div_y0 = (step_q == SP_GCD || step_q == SP_EUC) && stat.y_zero;

	always_comb begin
		cmd        = '0;
		cmd.step   = step_q;
		cmd.code   = code_q;
		cmd.load   = accept;
		cmd.emit   = emit;
		if (st_q == S_RUN) begin
			if (!ph_q) begin
				cmd.start  = !div_y0;
				cmd.commit = div_y0 && step_q == SP_GCD;
			end else begin
				cmd.commit = !stat.busy;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			step_q      <= SP_RRED;
			ph_q        <= 1'b0;
			code_q      <= ST_MERGED;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit ? 1'b1 : (out_stall && out_valid_q);
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						step_q <= SP_RRED;
						ph_q   <= 1'b0;
						if (stat.m_zero) begin
							code_q <= ST_ZERO_MOD;
							st_q   <= S_DONE;
						end else begin
							st_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (!ph_q) begin
						if (div_y0) begin
							step_q <= (step_q == SP_GCD) ? SP_QM : SP_K;
						end else begin
							ph_q <= 1'b1;
						end
					end else if (!stat.busy) begin
						ph_q <= 1'b0;
						case (step_q)
							SP_AG: begin
								if (stat.mis) begin
									code_q <= ST_NO_SOL;
									st_q   <= S_DONE;
								end else begin
									step_q <= SP_LIM;
								end
							end
							SP_LIM: begin
								if (stat.ovf) begin
									code_q <= ST_OVERFLOW;
									st_q   <= S_DONE;
								end else if (!stat.q_gt1) begin
									code_q <= ST_MERGED;
									st_q   <= S_DONE;
								end else begin
									step_q <= SP_DIFF;
								end
							end
							SP_RRED: step_q <= SP_GCD;
							SP_GCD:  step_q <= SP_GCD;
							SP_QM:   step_q <= SP_RG;
							SP_RG:   step_q <= SP_AG;
							SP_DIFF: step_q <= SP_DMOD;
							SP_DMOD: step_q <= SP_PG;
							SP_PG:   step_q <= SP_R0;
							SP_R0:   step_q <= SP_EUC;
							SP_EUC:  step_q <= SP_SUPD;
							SP_SUPD: step_q <= SP_EUC;
							SP_K:    step_q <= SP_PQ;
							SP_PQ:   step_q <= SP_PK;
							SP_PK: begin
								code_q <= ST_MERGED;
								st_q   <= S_DONE;
							end
							default: st_q <= S_IDLE;
						endcase
					end
				end
				S_DONE: begin
					if (emit) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = st_q != S_IDLE;
	assign out_valid = out_valid_q;
endmodule

// ===== hw/rtl/online_crt_merger.sv =====
// Each item is a sequence of serial divisions and modular multiplies: the fixed steps, the gcd
// loop and the Euclid loop, each Euclid step being one division and one modular multiply.
// Throughput: one item at a time; the shared serial divider and multiplier set the rate.
// A zero modulus finishes straight from idle with status ST_ZERO_MOD.
// Reset (arst_n low, asynchronous) sets the internal period to 1 and residue to 0 and drops out_valid.
module online_crt_merger import crtm_pkg::*; #(
	parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        restart,
	input  logic [63:0] modulus,
	input  logic [63:0] remainder,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [62:0] period,
	output logic [62:0] residue
);
	cmd_t  cmd;
	stat_t stat;

	crtm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
	);

	crtm_dp #(.WORD_BITS(WORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .restart(restart),
		.modulus(modulus), .remainder(remainder), .status(status),
		.period(period), .residue(residue)
	);
endmodule
